// ===== sv/middle_insert_queue_defines.svh =====
// Assertion macros for the middle insertion queue.
// Included by the top level; no other dependencies.
`ifndef MIDDLE_INSERT_QUEUE_DEFINES_SVH
`define MIDDLE_INSERT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MIQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/miq_pkg.sv =====
// Shared types and constants for the middle insertion queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package miq_pkg;

    localparam int MIQ_HALF_DEPTH = 1024;
    localparam int MIQ_ID_BITS    = 32;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_POP    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_FIN  = 1'b1
    } t_state;

    typedef struct packed {
        logic exec;    // request accepted: decode, memory access, pointer update
        logic finish;  // rebalance write and result load
    } t_ctl;

endpackage

`default_nettype wire

// ===== sv/middle_insert_queue.sv =====
// Middle insertion queue: push to back, insert at middle, pop from front.
// One request channel (i_valid / o_ready, i_command, i_item_id) and one
// result channel (o_valid / i_ready, o_popped_id, o_popped_valid, o_status).
// Each request gives exactly one result, in request order.
// The queue is two rings of HALF_DEPTH entries; after every request the
// front half holds as many entries as the back half or one more.
// o_valid rises once the request has passed S_FIN and its result is loaded
// into the output register. A new request is not taken before the last one is
// through, since pop and rebalance need registered store reads before the rebalance write.
// o_ready is high only while no request is in flight; a finished result
// sits in the output register while the next request is taken.
// If the receiver stalls, the block holds its in-flight result and stops
// taking requests until the output register frees.
// Reset (synchronous, active low) empties the queue at once; store contents
// need no clearing.
// Pop on empty gives status 1; push or insert on a full queue gives status 2.
// Depends on miq_pkg, miq_ctrl, miq_datapath, middle_insert_queue_defines.svh.
`default_nettype none

`include "middle_insert_queue_defines.svh"

module middle_insert_queue #(
    parameter int HALF_DEPTH = miq_pkg::MIQ_HALF_DEPTH,
    parameter int ID_BITS    = miq_pkg::MIQ_ID_BITS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [1:0]          i_command,
    input  wire  [ID_BITS-1:0]  i_item_id,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [ID_BITS-1:0]  o_popped_id,
    output logic                o_popped_valid,
    output logic [1:0]          o_status
);
    import miq_pkg::*;

    t_ctl ctl;

    miq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_ctl   (ctl)
    );

    miq_datapath #(
        .HALF_DEPTH (HALF_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_command      (i_command),
        .i_item_id      (i_item_id),
        .o_popped_id    (o_popped_id),
        .o_popped_valid (o_popped_valid),
        .o_status       (o_status)
    );

    `MIQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second request taken while busy")
    `MIQ_ASSERT_NOW(a_pop_ok, i_clk, i_rst_n, o_valid && o_popped_valid, o_status == ST_OK, "popped value with error status")
    `MIQ_ASSERT_NOW(a_no_pop_zero, i_clk, i_rst_n, o_valid && !o_popped_valid, o_popped_id == '0, "nonzero id without pop")
    `MIQ_ASSERT_NOW(a_finish_free, i_clk, i_rst_n, ctl.finish, !o_valid || i_ready, "result overwrites pending output")

endmodule

`default_nettype wire

// ===== sv/miq_ctrl.sv =====
// Sequencer for the middle insertion queue: request acceptance and result hand-off.
// Depends on miq_pkg.
`default_nettype none

module miq_ctrl (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    input  wire          i_ready,
    output logic         o_ready,
    output logic         o_valid,
    output miq_pkg::t_ctl o_ctl
);
    import miq_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_ctl       = '0;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_ctl.exec = i_valid;
            end
            S_FIN: begin
                o_ctl.finish = out_free;
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== sv/miq_datapath.sv =====
// Datapath of the middle insertion queue: two ring stores, pointers, counts, result regs.
// Depends on miq_pkg; driven by miq_ctrl through t_ctl.
`default_nettype none

module miq_datapath #(
    parameter int HALF_DEPTH = miq_pkg::MIQ_HALF_DEPTH,
    parameter int ID_BITS    = miq_pkg::MIQ_ID_BITS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  miq_pkg::t_ctl       i_ctl,
    input  wire  [1:0]          i_command,
    input  wire  [ID_BITS-1:0]  i_item_id,
    output logic [ID_BITS-1:0]  o_popped_id,
    output logic                o_popped_valid,
    output logic [1:0]          o_status
);
    import miq_pkg::*;

    localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int CW = $clog2(HALF_DEPTH + 1);
    localparam logic [AW-1:0] LAST     = AW'(HALF_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(HALF_DEPTH);
    localparam logic [CW-1:0] ONE      = CW'(1);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - AW'(1);
    endfunction

    logic [ID_BITS-1:0] r_front_mem [HALF_DEPTH];
    logic [ID_BITS-1:0] r_back_mem  [HALF_DEPTH];

    logic [AW-1:0] r_fh, n_fh, r_ft, n_ft, r_bh, n_bh, r_bt, n_bt;
    logic [CW-1:0] r_fc, n_fc, r_bc, n_bc;

    logic [ID_BITS-1:0] r_front_rd, r_back_rd, r_id;
    logic               r_move, r_bypass, r_pop;
    t_status            r_res_status;

    logic [ID_BITS-1:0] r_out_id;
    logic               r_out_pop;
    t_status            r_out_status;

    logic               fw_en, bw_en, mv, byp, pop;
    logic [AW-1:0]      fw_addr, bw_addr;
    logic [ID_BITS-1:0] fw_data;
    t_status            st;
    logic               full, eq;

    assign full = (r_fc == FULL_CNT) && (r_bc == FULL_CNT);
    assign eq   = (r_fc == r_bc);

    always_comb begin
        n_fh = r_fh; n_ft = r_ft; n_bh = r_bh; n_bt = r_bt;
        n_fc = r_fc; n_bc = r_bc;
        fw_en = 1'b0; fw_addr = r_ft; fw_data = i_item_id;
        bw_en = 1'b0; bw_addr = r_bt;
        mv = 1'b0; byp = 1'b0; pop = 1'b0; st = ST_OK;
        if (i_ctl.exec) begin
            case (i_command)
                CMD_PUSH: begin
                    if (full) begin
                        st = ST_FULL;
                    end else begin
                        bw_en = 1'b1;
                        n_bt  = ring_next(r_bt);
                        if (eq) begin
                            // back grows past front: its head moves over
                            mv   = 1'b1;
                            byp  = (r_bc == '0);
                            n_bh = ring_next(r_bh);
                        end else begin
                            n_bc = r_bc + ONE;
                        end
                    end
                end
                CMD_INSERT: begin
                    if (full) begin
                        st = ST_FULL;
                    end else if (eq) begin
                        fw_en = 1'b1;
                        n_ft  = ring_next(r_ft);
                        n_fc  = r_fc + ONE;
                    end else begin
                        bw_en   = 1'b1;
                        bw_addr = ring_prev(r_bh);
                        n_bh    = ring_prev(r_bh);
                        n_bc    = r_bc + ONE;
                    end
                end
                CMD_POP: begin
                    if (r_fc == '0) begin
                        st = ST_EMPTY;
                    end else begin
                        pop  = 1'b1;
                        n_fh = ring_next(r_fh);
                        n_fc = r_fc - ONE;
                        if (eq) begin
                            mv   = 1'b1;
                            n_bh = ring_next(r_bh);
                            n_bc = r_bc - ONE;
                        end
                    end
                end
                default: ;
            endcase
        end else if (i_ctl.finish && r_move) begin
            fw_en   = 1'b1;
            fw_addr = r_ft;
            fw_data = r_bypass ? r_id : r_back_rd;
            n_ft    = ring_next(r_ft);
            n_fc    = r_fc + ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fw_en) begin
            r_front_mem[fw_addr] <= fw_data;
        end
        if (i_ctl.exec) begin
            r_front_rd <= r_front_mem[r_fh];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bw_en) begin
            r_back_mem[bw_addr] <= i_item_id;
        end
        if (i_ctl.exec) begin
            r_back_rd <= r_back_mem[r_bh];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fh <= '0; r_ft <= '0; r_bh <= '0; r_bt <= '0;
            r_fc <= '0; r_bc <= '0;
        end else begin
            r_fh <= n_fh; r_ft <= n_ft; r_bh <= n_bh; r_bt <= n_bt;
            r_fc <= n_fc; r_bc <= n_bc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_id         <= i_item_id;
            r_move       <= mv;
            r_bypass     <= byp;
            r_pop        <= pop;
            r_res_status <= st;
        end
        if (i_ctl.finish) begin
            r_out_id     <= r_pop ? r_front_rd : '0;
            r_out_pop    <= r_pop;
            r_out_status <= r_res_status;
        end
    end

    assign o_popped_id    = r_out_id;
    assign o_popped_valid = r_out_pop;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire

// ===== tb/middle_insert_queue_tb.sv =====
// Self-checking testbench for middle_insert_queue: directed corner cases, a drain to empty
// and a random run, all checked against a two-ring queue model.
// Depends on miq_pkg and the middle_insert_queue RTL only.
`timescale 1ns / 100ps

module middle_insert_queue_tb;
    import miq_pkg::*;

    localparam int ID_W            = MIQ_ID_BITS;
    localparam int DEPTH           = MIQ_HALF_DEPTH;
    localparam int RANDOM_ITEMS    = 900;
    localparam int QUIET_TAIL      = 150;
    localparam int DRAIN_WAIT      = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [ID_W-1:0] popped_id;
        logic            popped_valid;
        t_status         status;
    } t_queue_result;

    // Two-ring model of the queue plus the results still owed by the block.
    class t_queue_tracker;
        logic [ID_W-1:0] front_ring [DEPTH];
        logic [ID_W-1:0] back_ring  [DEPTH];
        int front_head  = 0;
        int front_tail  = 0;
        int back_head   = 0;
        int back_tail   = 0;
        int front_count = 0;
        int back_count  = 0;
        int mismatches  = 0;
        t_queue_result awaited_results[$];

        task report_mismatch(input string msg);
            $display("%0t MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        function void append_front(input logic [ID_W-1:0] id);
            front_ring[front_tail] = id;
            front_tail = (front_tail + 1) % DEPTH;
            front_count++;
        endfunction

        // keep front_count equal to back_count or one more
        function void shift_to_front();
            if (front_count < back_count) begin
                append_front(back_ring[back_head]);
                back_head = (back_head + 1) % DEPTH;
                back_count--;
            end
        endfunction

        function void note_request(input logic [1:0] cmd, input logic [ID_W-1:0] id);
            t_queue_result r;
            logic          full;
            r.popped_id    = '0;
            r.popped_valid = 1'b0;
            r.status       = ST_OK;
            full = (front_count == DEPTH) && (back_count == DEPTH);
            case (cmd)
                CMD_PUSH: begin
                    if (full) begin
                        r.status = ST_FULL;
                    end else begin
                        back_ring[back_tail] = id;
                        back_tail = (back_tail + 1) % DEPTH;
                        back_count++;
                        shift_to_front();
                    end
                end
                CMD_INSERT: begin
                    if (full) begin
                        r.status = ST_FULL;
                    end else if (front_count == back_count) begin
                        append_front(id);
                    end else begin
                        back_head = (back_head + DEPTH - 1) % DEPTH;
                        back_ring[back_head] = id;
                        back_count++;
                        shift_to_front();
                    end
                end
                CMD_POP: begin
                    if (front_count == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped_id    = front_ring[front_head];
                        r.popped_valid = 1'b1;
                        front_head = (front_head + 1) % DEPTH;
                        front_count--;
                        shift_to_front();
                    end
                end
                default: ;
            endcase
            awaited_results.push_back(r);
        endfunction

        task check_result(input logic [ID_W-1:0] popped_id, input logic popped_valid,
                          input logic [1:0] status);
            t_queue_result want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = awaited_results.pop_front();
                if (popped_id !== want.popped_id)
                    report_mismatch($sformatf("popped_id got %h want %h",
                                              popped_id, want.popped_id));
                if (popped_valid !== want.popped_valid)
                    report_mismatch($sformatf("popped_valid got %b want %b",
                                              popped_valid, want.popped_valid));
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, want.status));
            end
        endtask
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    logic [1:0]      i_command;
    logic [ID_W-1:0] i_item_id;
    logic            o_valid;
    logic            i_ready;
    logic [ID_W-1:0] o_popped_id;
    logic            o_popped_valid;
    logic [1:0]      o_status;

    t_queue_tracker tracker;
    bit             idle_bursts = 1'b1;
    int             queue_level = 0;

    middle_insert_queue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_item_id      (i_item_id),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_popped_id    (o_popped_id),
        .o_popped_valid (o_popped_valid),
        .o_status       (o_status)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                tracker.note_request(i_command, i_item_id);
            if (o_valid && i_ready)
                tracker.check_result(o_popped_id, o_popped_valid, o_status);
        end
    end

    // result side back-pressure
    initial begin
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (idle_bursts && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    function automatic logic [ID_W-1:0] random_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(input logic [1:0] cmd, input logic [ID_W-1:0] id);
        if (idle_bursts && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_item_id <= id;
        do @(posedge i_clk); while (!o_ready);
        if ((cmd == CMD_PUSH || cmd == CMD_INSERT) && queue_level < 2 * DEPTH)
            queue_level++;
        else if (cmd == CMD_POP && queue_level > 0)
            queue_level--;
    endtask

    initial begin
        int         done;
        int         pick;
        int         pop_weight;
        logic [1:0] cmd;

        tracker   = new();
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_command <= CMD_PUSH;
        i_item_id <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        issue(CMD_POP, '1);
        issue(CMD_UNUSED, 32'hDEAD_BEEF);
        issue(CMD_INSERT, 32'h0000_0001);
        issue(CMD_INSERT, 32'hFFFF_FFFF);
        issue(CMD_PUSH, 32'h0000_0000);
        issue(CMD_INSERT, 32'h8000_0000);
        issue(CMD_PUSH, 32'hAAAA_AAAA);
        issue(CMD_INSERT, 32'h5555_5555);
        issue(CMD_PUSH, 32'h7FFF_FFFF);
        issue(CMD_UNUSED, '0);
        issue(CMD_POP, 32'h1234_5678);
        issue(CMD_INSERT, 32'hFFFF_FFFE);
        while (queue_level > 0)
            issue(CMD_POP, '0);
        issue(CMD_POP, '0);

        // random walk with drifting pop weight
        done = 0;
        pop_weight = 40;
        while (done < RANDOM_ITEMS) begin
            if (done % 100 == 0)
                pop_weight = $urandom_range(20, 60);
            if (done >= RANDOM_ITEMS - QUIET_TAIL)
                idle_bursts = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                cmd = CMD_UNUSED;
            else if (pick < 4 + pop_weight)
                cmd = CMD_POP;
            else
                cmd = pick[0] ? CMD_PUSH : CMD_INSERT;
            issue(cmd, random_id());
            if (cmd != CMD_UNUSED)
                done++;
        end
        i_valid <= 1'b0;

        for (int n = 0; n < DRAIN_WAIT && tracker.awaited_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.awaited_results.size() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.awaited_results.size()));

        if (tracker.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/miq_pkg.sv
sv/miq_ctrl.sv
sv/miq_datapath.sv
sv/middle_insert_queue.sv
tb/middle_insert_queue_tb.sv
